>>> src/rrs_pkg.sv
// Shared types, codes and constants of the round-robin sleep task scheduler.
package rrs_pkg;

  localparam int MAX_TASKS_DEFAULT = 16;
  localparam int TIU_W             = 5;
  localparam int STEP_W            = 8;
  localparam int KIND_W            = 3;
  localparam int NUM_W             = 4;
  localparam int TIME_W            = 16;
  localparam int COUNT_W           = 17;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 8;

  localparam logic [TIU_W-1:0]  TIU_RESET  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_RESET = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TASKS_IN_USE = 1'd0,
    REG_TICK_STEP    = 1'd1
  } reg_index_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 3'd0,
    KIND_SCHEDULE = 3'd1,
    KIND_DELAY    = 3'd2,
    KIND_QUIT     = 3'd3,
    KIND_START    = 3'd4,
    KIND_STOP     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    TASK_READY    = 2'd0,
    TASK_RUNNING  = 2'd1,
    TASK_SLEEPING = 2'd2,
    TASK_DEAD     = 2'd3
  } task_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NUM_W-1:0]  task_number;
    logic [TIME_W-1:0] sleep_time;
  } request_t;

  typedef struct packed {
    logic             launched;
    logic [NUM_W-1:0] picked_task;
  } result_t;

  // One task table entry; the all-zero word is the reset entry.
  typedef struct packed {
    logic                       armed;
    logic signed [COUNT_W-1:0]  countdown;
    task_state_t                state;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_t             kind;
    logic              target_ok;
    logic [STEP_W-1:0] tick_step;
    logic [TIME_W-1:0] sleep_time;
  } upd_ctrl_t;

  typedef struct packed {
    logic   write;
    logic   launched;
    entry_t entry;
  } upd_out_t;

endpackage

>>> src/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/rrs_update.sv
// Entry modify logic: new task entry, write enable and launch flag per item kind.
module rrs_update (
  input  rrs_pkg::upd_ctrl_t ctrl,
  input  rrs_pkg::entry_t    cur,
  output rrs_pkg::upd_out_t  upd
);
  import rrs_pkg::*;

  always_comb begin
    upd.write    = 1'b0;
    upd.launched = 1'b0;
    upd.entry    = cur;
    unique case (ctrl.kind)
      KIND_TICK: begin
        upd.write = 1'b1;
        if (cur.countdown <= $signed(COUNT_W'(0))) begin
          upd.entry = '0;
          upd.entry.state = TASK_READY;
        end else begin
          upd.entry.countdown = cur.countdown
                              - $signed({{(COUNT_W-STEP_W){1'b0}}, ctrl.tick_step});
        end
      end
      KIND_SCHEDULE: begin
        upd.write = 1'b1;
        if (cur.state == TASK_READY) begin
          upd.entry.state = TASK_RUNNING;
        end
        upd.launched = (cur.state == TASK_READY) || (cur.state == TASK_RUNNING);
      end
      KIND_DELAY: begin
        // ignore while a sleep is already armed
        if (!cur.armed) begin
          upd.write           = 1'b1;
          upd.entry.armed     = 1'b1;
          upd.entry.state     = TASK_SLEEPING;
          upd.entry.countdown = $signed({{(COUNT_W-TIME_W){1'b0}}, ctrl.sleep_time});
        end
      end
      KIND_QUIT: begin
        upd.write       = 1'b1;
        upd.entry.state = TASK_DEAD;
      end
      KIND_START: begin
        upd.write       = ctrl.target_ok;
        upd.entry.state = TASK_READY;
      end
      KIND_STOP: begin
        upd.write       = ctrl.target_ok;
        upd.entry.state = TASK_DEAD;
      end
      default: begin
        upd.write = 1'b0;
      end
    endcase
  end

endmodule

>>> src/round_robin_sleep_task_scheduler_top.sv
// Top level of the round-robin sleep task scheduler: sequencer, task table and config.
//
//   channel   direction  handshake                     payload
//   request   in         request_valid / request_stall rrs_pkg::request_t
//   result    out        result_valid / result_stall   rrs_pkg::result_t
//   config    in         cfg_we, cfg_index             cfg_data
//
// A schedule, delay, quit, start or stop request holds the block through the table read,
// the modify and write back state and the result load. A tick holds it while it walks the
// table one entry per cycle through the single RAM read port, writing each entry back, over
// the n entries of the clamped task count, then loads its result. An unknown kind skips the
// table and goes straight to the result load.
// Reset is synchronous; the table needs no clearing pass, since per-entry valid bits
// make unwritten entries read as ready with a zero countdown.
// A stalled result holds in the output register; requests stall until it can load.
module round_robin_sleep_task_scheduler_top #(
  parameter int MAX_TASKS = rrs_pkg::MAX_TASKS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  request_valid,
  output logic                                  request_stall,
  input  rrs_pkg::request_t                     request,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output rrs_pkg::result_t                      result,
  input  logic                                  cfg_we,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rrs_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int PTR_W = $clog2(MAX_TASKS + 1);
  localparam int CNT_W = (PTR_W > TIU_W) ? PTR_W : TIU_W;
  localparam int NCM_W = (PTR_W > NUM_W) ? PTR_W : NUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } fsm_t;

  fsm_t state, state_next;

  // configuration registers
  logic [TIU_W-1:0]  tasks_in_use;
  logic [STEP_W-1:0] tick_step;

  // scheduler registers
  logic [PTR_W-1:0]  rr_pointer;
  logic [IDX_W-1:0]  last_picked;
  logic [IDX_W-1:0]  walk_idx;
  logic [IDX_W-1:0]  op_addr;
  kind_t             item_kind;
  logic              item_target_ok;
  logic [TIME_W-1:0] item_time;
  logic              res_launched;
  logic [NUM_W-1:0]  res_picked;

  // table valid bits, tracked alongside the RAM read
  logic [MAX_TASKS-1:0] entry_valid;
  logic                 rd_valid;

  // RAM ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_q;

  entry_t    cur_entry;
  upd_ctrl_t ctrl;
  upd_out_t  upd;

  logic             accept;
  logic [PTR_W-1:0] n_in_use;
  logic [CNT_W-1:0] tiu_ext;
  logic [IDX_W-1:0] sched_pick;
  logic             num_ok;
  logic [PTR_W-1:0] walk_succ;
  logic             walk_more;
  logic             out_free;

  assign accept        = request_valid && !request_stall;
  assign request_stall = (state != S_IDLE);
  assign out_free      = !result_valid || !result_stall;

  // clamp the task count: zero acts as one, above the table size acts as the table size
  always_comb begin
    tiu_ext = CNT_W'(tasks_in_use);
    if (tiu_ext == '0) begin
      n_in_use = PTR_W'(1);
    end else if (tiu_ext > CNT_W'(MAX_TASKS)) begin
      n_in_use = PTR_W'(MAX_TASKS);
    end else begin
      n_in_use = PTR_W'(tiu_ext);
    end
  end

  // wrap the pointer to entry 0 when it sits at or past the count in use
  assign sched_pick = (rr_pointer >= n_in_use) ? '0 : IDX_W'(rr_pointer);
  assign num_ok     = NCM_W'(request.task_number) < NCM_W'(MAX_TASKS);
  assign walk_succ  = PTR_W'(walk_idx) + PTR_W'(1);
  assign walk_more  = walk_succ < n_in_use;

  // RAM read address: issued at accept for the addressed entry, then per walk step
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state == S_IDLE) begin
      ram_re = accept;
      case (request.kind)
        KIND_TICK:     ram_raddr = '0;
        KIND_SCHEDULE: ram_raddr = sched_pick;
        KIND_DELAY,
        KIND_QUIT:     ram_raddr = last_picked;
        default:       ram_raddr = IDX_W'(request.task_number);
      endcase
    end else if (state == S_WALK) begin
      ram_re    = walk_more;
      ram_raddr = IDX_W'(walk_succ);
    end
  end

  assign cur_entry = rd_valid ? entry_t'(ram_q) : entry_t'('0);

  assign ctrl.kind       = item_kind;
  assign ctrl.target_ok  = item_target_ok;
  assign ctrl.tick_step  = tick_step;
  assign ctrl.sleep_time = item_time;

  rrs_update u_update (
    .ctrl (ctrl),
    .cur  (cur_entry),
    .upd  (upd)
  );

  assign ram_we    = ((state == S_MOD) && upd.write) || (state == S_WALK);
  assign ram_waddr = (state == S_WALK) ? walk_idx : op_addr;

  rrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (upd.entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.kind)
            KIND_TICK:     state_next = S_WALK;
            KIND_SCHEDULE,
            KIND_DELAY,
            KIND_QUIT,
            KIND_START,
            KIND_STOP:     state_next = S_MOD;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_MOD:  state_next = S_DONE;
      S_WALK: state_next = walk_more ? S_WALK : S_DONE;
      S_DONE: state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tasks_in_use <= TIU_RESET;
      tick_step    <= STEP_RESET;
      rr_pointer   <= '0;
      last_picked  <= '0;
      entry_valid  <= '0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_TASKS_IN_USE: tasks_in_use <= cfg_data[TIU_W-1:0];
          REG_TICK_STEP:    tick_step    <= cfg_data[STEP_W-1:0];
          default:          tick_step    <= tick_step;
        endcase
      end

      // advance the round-robin pointer as the schedule request enters
      if (accept && (request.kind == KIND_SCHEDULE)) begin
        rr_pointer  <= PTR_W'(sched_pick) + PTR_W'(1);
        last_picked <= sched_pick;
      end

      if (ram_re) begin
        rd_valid <= entry_valid[ram_raddr];
      end
      if (ram_we) begin
        entry_valid[ram_waddr] <= 1'b1;
      end

      // drop the result once taken, load the next one from the done state
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind      <= kind_t'(request.kind);
      item_target_ok <= num_ok;
      item_time      <= request.sleep_time;
      walk_idx       <= '0;
      res_launched   <= 1'b0;
      res_picked     <= (request.kind == KIND_SCHEDULE) ? NUM_W'(sched_pick) : '0;
      case (request.kind)
        KIND_SCHEDULE: op_addr <= sched_pick;
        KIND_DELAY,
        KIND_QUIT:     op_addr <= last_picked;
        default:       op_addr <= IDX_W'(request.task_number);
      endcase
    end
    if (state == S_MOD) begin
      res_launched <= upd.launched;
    end
    if ((state == S_WALK) && walk_more) begin
      walk_idx <= IDX_W'(walk_succ);
    end
    if ((state == S_DONE) && out_free) begin
      result.launched    <= res_launched;
      result.picked_task <= res_picked;
    end
  end

endmodule

>>> bench/tb_round_robin_sleep_task_scheduler_top.sv
// Self-checking testbench for the round-robin sleep task scheduler top level.
`timescale 1ns / 1ps

module tb_round_robin_sleep_task_scheduler_top;
  import rrs_pkg::*;

  localparam int NTASK      = MAX_TASKS_DEFAULT;
  localparam int IDLE_LIMIT = 2000;  // cycles with no request or result moving
  localparam int HOLD_LEN   = 300;   // long receiver hold-off, well past the block's buffering
  localparam int SHOW_MAX   = 10;

  // Kind codes outside the defined set; the block must treat them as no-ops.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  request_valid = 1'b0;
  logic                  request_stall;
  request_t              request       = '0;
  logic                  result_valid;
  logic                  result_stall  = 1'b0;
  result_t               result;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  round_robin_sleep_task_scheduler_top u_top (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow task table: our own copy of every entry, the pointer and the
  // registers. It advances once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  task_state_t               shadow_state [NTASK];
  logic signed [COUNT_W-1:0] shadow_count [NTASK];
  logic                      shadow_armed [NTASK];
  logic [TIU_W-1:0]          shadow_ptr;
  logic [NUM_W-1:0]          shadow_last;
  logic [TIU_W-1:0]          shadow_tiu;
  logic [STEP_W-1:0]         shadow_step;

  request_t request_backlog [$];  // requests waiting for the driver
  result_t  due_results [$];      // predicted results, oldest first

  int  send_wait;
  int  recv_wait;
  int  hold_left;
  int  holds_asked;
  int  holds_done;
  int  quiet_cycles;
  int  requests_sent;
  int  results_seen;
  int  launches_seen;
  int  fail_count;
  bit  no_idle;

  logic     next_valid;
  request_t next_request;
  result_t  oldest;

  // Apply one request to the shadow table and return the result it must produce.
  function automatic result_t schedule_outcome(request_t req);
    result_t outcome;
    int      n;
    int      k;
    outcome = '0;
    // Clamp the entry count: zero acts as one, anything past the table as the table size.
    n = (shadow_tiu == 0) ? 1 : (shadow_tiu > NTASK) ? NTASK : int'(shadow_tiu);
    case (req.kind)
      KIND_TICK: begin
        // Expire or count down every entry in use; expiry also revives dead entries.
        for (k = 0; k < n; k++) begin
          if (shadow_count[k] <= 0) begin
            shadow_state[k] = TASK_READY;
            shadow_count[k] = '0;
            shadow_armed[k] = 1'b0;
          end else begin
            shadow_count[k] = shadow_count[k] - $signed({9'd0, shadow_step});
          end
        end
      end
      KIND_SCHEDULE: begin
        // A pointer left past the end by a shrunk count picks entry 0.
        k = (shadow_ptr >= n) ? 0 : int'(shadow_ptr);
        if (shadow_state[k] == TASK_READY) shadow_state[k] = TASK_RUNNING;
        outcome.launched    = (shadow_state[k] == TASK_RUNNING);
        outcome.picked_task = NUM_W'(k);
        shadow_last         = NUM_W'(k);
        shadow_ptr          = TIU_W'(k + 1);
      end
      KIND_DELAY: begin
        // Only the first delay arms; further delays are dropped until a tick clears it.
        if (!shadow_armed[shadow_last]) begin
          shadow_armed[shadow_last] = 1'b1;
          shadow_state[shadow_last] = TASK_SLEEPING;
          shadow_count[shadow_last] = $signed({1'b0, req.sleep_time});
        end
      end
      KIND_QUIT:  shadow_state[shadow_last]     = TASK_DEAD;
      KIND_START: shadow_state[req.task_number] = TASK_READY;
      KIND_STOP:  shadow_state[req.task_number] = TASK_DEAD;
      default: ;
    endcase
    return outcome;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOW_MAX) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: pop the backlog, hold the payload while stalled, and
  // predict each request at the edge where it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
    end else begin
      next_valid   = request_valid;
      next_request = request;
      if (request_valid && !request_stall) begin
        due_results.push_back(schedule_outcome(request));
        requests_sent++;
        next_valid = 1'b0;
        send_wait  = no_idle ? 0 : $urandom_range(0, 7);
      end
      // Compute valid once per edge so a back-to-back request keeps it high.
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (request_backlog.size() > 0) begin
          next_request = request_backlog.pop_front();
          next_valid   = 1'b1;
        end
      end
      request_valid <= next_valid;
      request       <= next_request;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each accepted result against the oldest prediction,
  // then stall the next one for a random number of presented cycles. A hold-off
  // asked by the stimulus keeps stall high for a long stretch on its own count.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          note_failure($sformatf("result with no request pending: launched %0b picked %0d",
                                 result.launched, result.picked_task));
        end else begin
          oldest = due_results.pop_front();
          launches_seen += oldest.launched;
          if (result.launched !== oldest.launched ||
              result.picked_task !== oldest.picked_task) begin
            note_failure($sformatf({"result %0d: expected launched %0b picked %0d, ",
                                    "got launched %0b picked %0d"}, results_seen,
                                   oldest.launched, oldest.picked_task,
                                   result.launched, result.picked_task));
          end
        end
        recv_wait = no_idle ? 0 : $urandom_range(0, 7);
      end else if (result_valid && recv_wait > 0) begin
        recv_wait--;
      end
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_LEN;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      result_stall <= (hold_left > 0) || (recv_wait > 0);
    end
  end

  // Watchdog: abort when neither channel moves for too long.
  always @(posedge clk) begin
    if ((request_valid && !request_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [KIND_W-1:0] op, input logic [NUM_W-1:0] num,
                           input logic [TIME_W-1:0] stime);
    request_backlog.push_back('{kind: op, task_number: num, sleep_time: stime});
  endtask

  // Wait until every request is sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (request_backlog.size() != 0 || request_valid || due_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Write one register; the shadow copy follows at once since the block is idle.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_TASKS_IN_USE) shadow_tiu = data[TIU_W-1:0];
    else shadow_step = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly schedule/delay/tick traffic with short sleeps so that tasks cycle
  // through every state; a few long sleeps, quits, starts, stops and spare kinds.
  task automatic queue_random(input int count);
    int                i;
    int                pick;
    logic [KIND_W-1:0] op;
    logic [TIME_W-1:0] stime;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = KIND_SCHEDULE;
      else if (pick < 50) op = KIND_DELAY;
      else if (pick < 75) op = KIND_TICK;
      else if (pick < 81) op = KIND_QUIT;
      else if (pick < 89) op = KIND_START;
      else if (pick < 96) op = KIND_STOP;
      else                op = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;
      pick = $urandom_range(0, 9);
      if (pick < 7)      stime = TIME_W'($urandom_range(0, 40));
      else if (pick < 9) stime = TIME_W'($urandom_range(0, 600));
      else               stime = TIME_W'($urandom);
      queue_req(op, NUM_W'($urandom), stime);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    int ph;
    for (k = 0; k < NTASK; k++) begin
      shadow_state[k] = TASK_READY;
      shadow_count[k] = '0;
      shadow_armed[k] = 1'b0;
    end
    shadow_ptr  = '0;
    shadow_last = '0;
    shadow_tiu  = TIU_RESET;
    shadow_step = STEP_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk at the reset settings (two tasks, step of two).
    queue_req(KIND_DELAY,    4'd15, 16'd3);      // delay before any schedule hits entry 0
    queue_req(KIND_DELAY,    4'd0,  16'hFFFF);   // already armed: dropped
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);      // sleeping pick, not launched
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);      // ready pick becomes running
    queue_req(KIND_QUIT,     4'd0,  16'd0);
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);      // pointer wraps to 0
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);      // dead pick
    queue_req(KIND_TICK,     4'd0,  16'd0);      // revives the dead entry
    queue_req(KIND_TICK,     4'd0,  16'd0);      // countdown goes negative
    queue_req(KIND_TICK,     4'd0,  16'd0);      // negative countdown wakes
    queue_req(KIND_START,    4'd15, 16'd0);      // entry outside the count still written
    queue_req(KIND_STOP,     4'd15, 16'd0);
    queue_req(KIND_STOP,     4'd0,  16'd0);
    queue_req(KIND_SPARE_LO, 4'd15, 16'hFFFF);
    queue_req(KIND_SPARE_HI, 4'd0,  16'd0);
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);
    queue_req(KIND_START,    4'd0,  16'd0);
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);
    queue_req(KIND_DELAY,    4'd0,  16'hFFFF);   // longest sleep
    queue_req(KIND_SCHEDULE, 4'd0,  16'd0);      // running pick is launched again
    queue_req(KIND_DELAY,    4'd0,  16'd0);      // zero sleep wakes on the next tick
    queue_req(KIND_TICK,     4'd0,  16'd0);
    queue_req(KIND_QUIT,     4'd0,  16'd0);
    wait_drained();

    // Zero count acts as one (pointer now past the end), zero step freezes countdowns.
    write_reg(REG_TASKS_IN_USE, 8'd0);
    write_reg(REG_TICK_STEP,    8'd0);
    queue_req(KIND_SCHEDULE, 4'd0, 16'd0);
    queue_req(KIND_TICK,     4'd0, 16'd0);
    queue_req(KIND_TICK,     4'd0, 16'd0);
    queue_req(KIND_START,    4'd3, 16'd0);
    queue_random(100);
    wait_drained();

    // Full table, largest step; hold the receiver off so the block backs up.
    write_reg(REG_TASKS_IN_USE, 8'd16);
    write_reg(REG_TICK_STEP,    8'd255);
    holds_asked++;
    queue_random(150);
    wait_drained();

    // Count beyond the table (upper data bits ignored), smallest step, no idling.
    no_idle = 1'b1;
    write_reg(REG_TASKS_IN_USE, 8'hFF);
    write_reg(REG_TICK_STEP,    8'd1);
    queue_random(150);
    wait_drained();
    no_idle = 1'b0;

    write_reg(REG_TASKS_IN_USE, 8'd1);
    write_reg(REG_TICK_STEP,    8'd128);
    queue_random(100);

    for (ph = 0; ph < 3; ph++) begin
      wait_drained();
      write_reg(REG_TASKS_IN_USE, CFG_DATA_W'($urandom_range(1, 16)));
      write_reg(REG_TICK_STEP,    CFG_DATA_W'($urandom_range(1, 255)));
      queue_random(100);
    end

    wait_drained();
    repeat (24) @(posedge clk);

    $display("covered %0d requests and %0d results (%0d launches) over eight register settings",
             requests_sent, results_seen, launches_seen);
    $display("mismatching or unexpected results: %0d", fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
